>>> design/meu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package meu_pkg;

	localparam logic [3:0] MAX_VARIABLES = 4'd8;
	localparam logic [3:0] MAX_DEGREE    = 4'd8;
	localparam logic [3:0] MIN_DEGREE    = 4'd2;

	localparam int BINOM_W = 17;
	localparam logic [BINOM_W-1:0] BINOM_SAT = {BINOM_W{1'b1}};

	typedef logic [BINOM_W-1:0] binom_t;
	typedef binom_t [15:0][15:0] binom_tbl_t;

	typedef struct packed {
		logic [3:0]  num_variables;
		logic [3:0]  poly_degree;
		logic [15:0] coefficient_index;
	} cmd_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] variable_index;
		logic [3:0] exponent;
		logic       last;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_GRADE,
		ST_VAR,
		ST_LAST,
		ST_REJECT
	} state_t;

	// entry [r][k] is C(r+k, k), saturated
	function automatic binom_tbl_t build_binom_table();
		binom_tbl_t t;
		logic [BINOM_W:0] s;
		t = '0;
		s = '0;
		for (int r = 0; r < 16; r++) begin
			for (int k = 0; k < 16; k++) begin
				if (r == 0 || k == 0) begin
					t[r][k] = binom_t'(1);
				end else begin
					s = {1'b0, t[r-1][k]} + {1'b0, t[r][k-1]};
					t[r][k] = s[BINOM_W] ? BINOM_SAT : s[BINOM_W-1:0];
				end
			end
		end
		return t;
	endfunction

	localparam binom_tbl_t BINOM_TABLE = build_binom_table();

endpackage
`default_nettype wire

>>> design/monomial_exponent_unrank_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Graded monomial unranking unit.
// Pulse start with a command word (variable count, degree, coefficient index)
// while busy is low; the word is taken at that clock edge and busy rises.
// A sequencer drives one shared binomial-table lookup and compare-subtract
// unit: one check step, then one step per total degree tried, then one step
// per candidate exponent tried for each variable but the last, then one step
// for the last variable, or one rejection step after the check.
// Results come out at most one word per cycle on result, marked by
// result_valid for exactly one cycle: one word per variable in order, the last
// with last set, or a single rejection word (ok low, last set) for a bad
// count, degree or index. Each result word is registered from the step
// that makes it; the final word shows in the first cycle with busy low, and
// a new command may be taken in that same cycle.
// The receiver cannot stall: every result word must be taken when shown.
// Reset clears the sequencer to idle and drops result_valid; no request
// survives reset.
module monomial_exponent_unrank_unit (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire meu_pkg::cmd_t   cmd,
	output logic                 busy,
	output logic                 result_valid,
	output meu_pkg::result_t     result
);
	import meu_pkg::*;

	state_t      state_q;
	state_t      state_d;
	logic [3:0]  nv_q;
	logic [3:0]  deg_q;
	logic [15:0] rank_q;
	logic [3:0]  total_q;
	logic [3:0]  var_q;
	logic [3:0]  e_q;
	logic [3:0]  remaining_q;
	logic        result_valid_q;
	result_t     result_q;

	logic [3:0]  r_sel;
	logic [3:0]  k_sel;
	binom_t      binom;
	logic        fits;
	logic        bad_params;
	logic        var_last;
	logic        emit;
	result_t     emit_word;

	assign bad_params = (nv_q == 4'd0) || (nv_q > MAX_VARIABLES) ||
		(deg_q < MIN_DEGREE) || (deg_q > MAX_DEGREE);
	assign var_last = (({1'b0, var_q} + 5'd2) == {1'b0, nv_q});

	// shared lookup and compare
	always_comb begin
		case (state_q)
			ST_CHECK: begin
				r_sel = nv_q;
				k_sel = deg_q;
			end
			ST_GRADE: begin
				r_sel = nv_q - 4'd1;
				k_sel = total_q;
			end
			ST_VAR: begin
				r_sel = remaining_q - e_q;
				k_sel = nv_q - var_q - 4'd2;
			end
			default: begin
				r_sel = 4'd0;
				k_sel = 4'd0;
			end
		endcase
		binom = BINOM_TABLE[r_sel][k_sel];
		fits  = ({1'b0, rank_q} < binom);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_d = (bad_params || !fits) ? ST_REJECT : ST_GRADE;
			end
			ST_GRADE: begin
				if (fits) begin
					state_d = (nv_q == 4'd1) ? ST_LAST : ST_VAR;
				end
			end
			ST_VAR: begin
				if (fits && var_last) begin
					state_d = ST_LAST;
				end
			end
			ST_LAST:   state_d = ST_IDLE;
			ST_REJECT: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		emit      = 1'b0;
		emit_word = '0;
		case (state_q)
			ST_VAR: begin
				emit                     = fits;
				emit_word.ok             = 1'b1;
				emit_word.variable_index = var_q;
				emit_word.exponent       = e_q;
			end
			ST_LAST: begin
				emit                     = 1'b1;
				emit_word.ok             = 1'b1;
				emit_word.variable_index = nv_q - 4'd1;
				emit_word.exponent       = remaining_q;
				emit_word.last           = 1'b1;
			end
			ST_REJECT: begin
				emit           = 1'b1;
				emit_word.last = 1'b1;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			state_q        <= state_d;
			result_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= emit_word;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					nv_q   <= cmd.num_variables;
					deg_q  <= cmd.poly_degree;
					rank_q <= cmd.coefficient_index;
				end
			end
			ST_CHECK: begin
				total_q <= 4'd0;
			end
			ST_GRADE: begin
				if (fits) begin
					remaining_q <= total_q;
					e_q         <= total_q;
					var_q       <= 4'd0;
				end else begin
					rank_q  <= rank_q - binom[15:0];
					total_q <= total_q + 4'd1;
				end
			end
			ST_VAR: begin
				if (fits) begin
					remaining_q <= remaining_q - e_q;
					e_q         <= remaining_q - e_q;
					var_q       <= var_q + 4'd1;
				end else begin
					rank_q <= rank_q - binom[15:0];
					e_q    <= e_q - 4'd1;
				end
			end
			default: begin
				rank_q <= rank_q;
			end
		endcase
	end

	assign busy         = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef NO_ASSERTIONS
	a_idle_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |=> !result_valid)
		else $error("result word without a step that emits");

	a_reject_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.ok) |-> result.last)
		else $error("rejection word not marked last");

	a_var_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.ok) |-> (result.variable_index < nv_q))
		else $error("variable index beyond variable count");

	a_start_clean: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> !result_valid)
		else $error("result word shown as a new request starts");

	a_var_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_VAR) |-> (({1'b0, var_q} + 5'd2) <= {1'b0, nv_q}))
		else $error("variable step past the last but one variable");
`endif

endmodule
`default_nettype wire
